### hw/rtl/tmqv_pkg.sv
// tmqv_pkg: shared types and constants of the tilemap quad vertex generator
// no dependencies

package tmqv_pkg;

    // default coordinate width of the map counters
    localparam int COORD_BITS_DEF = 12;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT = 2'd1;

    // tile word layout
    localparam int WORD_BITS      = 16;
    localparam int FLIPX_BIT      = 15;
    localparam int FLIPY_BIT      = 14;
    localparam int IDX_BITS       = 14;
    localparam int ATLAS_COL_BITS = 4;   // atlas is 16 tiles wide
    localparam int TILE_PIX       = 16;  // tile edge in atlas pixels
    localparam int TILE_PIX_BITS  = 4;

    // texture coordinate widths
    localparam int TEX_X_BITS = 9;
    localparam int TEX_Y_BITS = 15;

    // quad queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // texture corners of one quad, flips already applied
    typedef struct packed {
        logic [TEX_X_BITS-1:0] tx_a;
        logic [TEX_X_BITS-1:0] tx_b;
        logic [TEX_Y_BITS-1:0] ty_a;
        logic [TEX_Y_BITS-1:0] ty_b;
    } t_tex;

    localparam int TEX_BITS = $bits(t_tex);

endpackage

### hw/rtl/tmqv_fifo.sv
// tmqv_fifo: small flop-based queue of quad descriptors
// uses tmqv_pkg only through its parent; depth must be a power of two

module tmqv_fifo #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_empty;

    always_comb begin
        n_wptr  = wr_en ? r_wptr + AW'(1) : r_wptr;
        n_rptr  = rd_en ? r_rptr + AW'(1) : r_rptr;
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### hw/rtl/tmqv_front.sv
// tmqv_front: map size registers, column/row counters and quad setup
// depends on tmqv_pkg

module tmqv_front #(
    parameter int COORD_BITS = tmqv_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmqv_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tmqv_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_push,
    input  logic [tmqv_pkg::WORD_BITS-1:0]     i_tile_word,
    output logic                              o_full,
    input  logic                              i_q_full,
    output logic                              o_q_wr,
    output logic [2*(COORD_BITS+1)+tmqv_pkg::TEX_BITS-1:0] o_q_data
);
    import tmqv_pkg::*;

    localparam int PB = COORD_BITS + 1;
    localparam int CW = (PB > CFG_DATA_BITS) ? PB : CFG_DATA_BITS;

    logic [PB-1:0]         r_width, n_width;
    logic [PB-1:0]         r_height, n_height;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;

    logic [CW-1:0] cfg_ext, cfg_max, cfg_eff;
    logic [PB-1:0] col_inc, row_inc, px, py;
    logic          accept, col_wrap, row_wrap, fx, fy;
    logic [TEX_X_BITS-1:0] tx_base, pix_x;
    logic [TEX_Y_BITS-1:0] ty_base, pix_y;
    t_tex          tex;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // zero acts as one, anything above the coordinate range clamps
    assign cfg_ext = CW'(i_cfg_data);
    assign cfg_max = CW'(1) << COORD_BITS;
    always_comb begin
        if (cfg_ext == '0) begin
            cfg_eff = CW'(1);
        end else if (cfg_ext > cfg_max) begin
            cfg_eff = cfg_max;
        end else begin
            cfg_eff = cfg_ext;
        end
    end

    assign col_inc  = PB'(r_col) + PB'(1);
    assign row_inc  = PB'(r_row) + PB'(1);
    assign col_wrap = (col_inc >= r_width);
    assign row_wrap = (row_inc >= r_height);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAP_WIDTH: begin
                    n_width = PB'(cfg_eff);
                    n_col   = '0;
                    n_row   = '0;
                end
                REG_MAP_HEIGHT: begin
                    n_height = PB'(cfg_eff);
                    n_col    = '0;
                    n_row    = '0;
                end
                default: ;
            endcase
        end else if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : row_inc[COORD_BITS-1:0];
            end else begin
                n_col = col_inc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= PB'(1);
            r_height <= PB'(1);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    // quad setup: bottom-left corner and flipped texture corners
    assign px = PB'(r_col);
    assign py = r_height - PB'(1) - PB'(r_row);

    assign fx      = i_tile_word[FLIPX_BIT];
    assign fy      = i_tile_word[FLIPY_BIT];
    assign pix_x   = TEX_X_BITS'(TILE_PIX);
    assign pix_y   = TEX_Y_BITS'(TILE_PIX);
    assign tx_base = TEX_X_BITS'({i_tile_word[ATLAS_COL_BITS-1:0],
                                  {TILE_PIX_BITS{1'b0}}});
    assign ty_base = TEX_Y_BITS'({i_tile_word[IDX_BITS-1:ATLAS_COL_BITS],
                                  {TILE_PIX_BITS{1'b0}}});

    always_comb begin
        tex.tx_a = tx_base + (fx ? pix_x : '0);
        tex.tx_b = tx_base + (fx ? '0 : pix_x);
        tex.ty_a = ty_base + (fy ? pix_y : '0);
        tex.ty_b = ty_base + (fy ? '0 : pix_y);
    end

    // empty cells only move the counters
    assign o_q_wr   = accept && (i_tile_word != '0);
    assign o_q_data = {px, py, tex};

endmodule

### hw/rtl/tmqv_back.sv
// tmqv_back: vertex sequencer, emits four corners per queued quad
// depends on tmqv_pkg

module tmqv_back #(
    parameter int COORD_BITS = tmqv_pkg::COORD_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_q_empty,
    input  logic [2*(COORD_BITS+1)+tmqv_pkg::TEX_BITS-1:0] i_q_data,
    output logic                                           o_q_rd,
    input  logic                                           i_pop,
    output logic                                           o_empty,
    output logic [COORD_BITS:0]                            o_pos_x,
    output logic [COORD_BITS:0]                            o_pos_y,
    output logic [tmqv_pkg::TEX_X_BITS-1:0]                o_tex_x,
    output logic [tmqv_pkg::TEX_Y_BITS-1:0]                o_tex_y,
    output logic                                           o_last_vertex
);
    import tmqv_pkg::*;

    localparam int PB = COORD_BITS + 1;
    localparam int QW = 2 * PB + TEX_BITS;

    // corner order: (x,y) (x+1,y) (x+1,y+1) (x,y+1)
    localparam logic [1:0] VTX_0 = 2'd0;
    localparam logic [1:0] VTX_1 = 2'd1;
    localparam logic [1:0] VTX_2 = 2'd2;
    localparam logic [1:0] VTX_3 = 2'd3;

    logic                  r_valid, n_valid;
    logic [1:0]            r_step, n_step;
    logic [PB-1:0]         r_pos_x, r_pos_y, v_pos_x, v_pos_y;
    logic [TEX_X_BITS-1:0] r_tex_x, v_tex_x;
    logic [TEX_Y_BITS-1:0] r_tex_y, v_tex_y;
    logic                  r_last, v_last;
    logic [PB-1:0]         px, py;
    t_tex                  tex;
    logic                  load;

    assign px  = i_q_data[QW-1 -: PB];
    assign py  = i_q_data[QW-PB-1 -: PB];
    assign tex = t_tex'(i_q_data[TEX_BITS-1:0]);

    // output register refills when empty or being taken
    assign load   = !i_q_empty && (!r_valid || i_pop);
    assign o_q_rd = load && (r_step == VTX_3);

    always_comb begin
        case (r_step)
            VTX_0: begin
                v_pos_x = px;
                v_pos_y = py;
                v_tex_x = tex.tx_a;
                v_tex_y = tex.ty_b;
                v_last  = 1'b0;
            end
            VTX_1: begin
                v_pos_x = px + PB'(1);
                v_pos_y = py;
                v_tex_x = tex.tx_b;
                v_tex_y = tex.ty_b;
                v_last  = 1'b0;
            end
            VTX_2: begin
                v_pos_x = px + PB'(1);
                v_pos_y = py + PB'(1);
                v_tex_x = tex.tx_b;
                v_tex_y = tex.ty_a;
                v_last  = 1'b0;
            end
            default: begin
                v_pos_x = px;
                v_pos_y = py + PB'(1);
                v_tex_x = tex.tx_a;
                v_tex_y = tex.ty_a;
                v_last  = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (load) begin
            n_valid = 1'b1;
            n_step  = r_step + 2'd1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= VTX_0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pos_x <= v_pos_x;
            r_pos_y <= v_pos_y;
            r_tex_x <= v_tex_x;
            r_tex_y <= v_tex_y;
            r_last  <= v_last;
        end
    end

    assign o_empty       = !r_valid;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_tex_x       = r_tex_x;
    assign o_tex_y       = r_tex_y;
    assign o_last_vertex = r_last;

endmodule

### hw/rtl/tilemap_quad_vertex_generator.sv
// tilemap_quad_vertex_generator: top level, front + quad queue + vertex back end
// path: a non-empty tile word goes via the quad queue into the back end's output register
// rate: non-empty tiles share the single vertex output of the back end, four words each;
//   empty tiles go through the front at one word a cycle while the quad queue has room
// reset (sync, active low): map width/height 1, counters 0, queue and output empty

module tilemap_quad_vertex_generator #(
    parameter int COORD_BITS = tmqv_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [tmqv_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tmqv_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // tile word input
    input  logic                              push,
    output logic                              full,
    input  logic [tmqv_pkg::WORD_BITS-1:0]     i_tile_word,
    // vertex output
    output logic                              empty,
    input  logic                              pop,
    output logic [COORD_BITS:0]               o_pos_x,
    output logic [COORD_BITS:0]               o_pos_y,
    output logic [tmqv_pkg::TEX_X_BITS-1:0]    o_tex_x,
    output logic [tmqv_pkg::TEX_Y_BITS-1:0]    o_tex_y,
    output logic                              o_last_vertex
);
    import tmqv_pkg::*;

    localparam int PB = COORD_BITS + 1;
    localparam int QW = 2 * PB + TEX_BITS;

    // quad queue between front and back
    logic          q_wr, q_rd, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    // front: config registers, raster counters, empty-cell skip, quad setup
    tmqv_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_tile_word (i_tile_word),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_q_data    (q_wdata)
    );

    // decouples word intake from vertex output
    tmqv_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    // back: one vertex word per cycle into the output register while a quad is queued and the output is free or popped
    tmqv_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_tex_x       (o_tex_x),
        .o_tex_y       (o_tex_y),
        .o_last_vertex (o_last_vertex)
    );

`ifndef SYNTHESIS
    // a quad leaves the queue only as its fourth corner is loaded
    a_quad_retire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |=> (!empty && o_last_vertex))
        else $error("quad retired without a last vertex word");

    // an accepted empty cell never reaches the queue
    a_empty_cell_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_tile_word == '0)) |-> !q_wr)
        else $error("empty tile word queued a quad");

    // a queued quad is visible to the back end next cycle
    a_queue_write_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |=> !q_empty)
        else $error("queued quad lost");
`endif

endmodule

### sim/tmqv_vertex_checker.sv
// tmqv_vertex_checker: scoreboard for the tilemap quad vertex generator
// tracks the map counters, predicts four corners per non-empty tile word and
// compares them with the vertex stream; depends on tmqv_pkg

module tmqv_vertex_checker #(
    parameter int COORD_BITS = tmqv_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tmqv_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tmqv_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic [tmqv_pkg::WORD_BITS-1:0]     i_tile_word,
    input  logic                               i_empty,
    input  logic                               i_pop,
    input  logic [COORD_BITS:0]                i_pos_x,
    input  logic [COORD_BITS:0]                i_pos_y,
    input  logic [tmqv_pkg::TEX_X_BITS-1:0]    i_tex_x,
    input  logic [tmqv_pkg::TEX_Y_BITS-1:0]    i_tex_y,
    input  logic                               i_last_vertex,
    output int                                 o_fail_count,
    output int                                 o_vertices_due,
    output int                                 o_vertices_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tmqv_pkg::*;

    localparam int POS_W       = COORD_BITS + 1;
    localparam int DIM_MAX     = 1 << COORD_BITS;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic [TEX_X_BITS-1:0] tex_x;
        logic [TEX_Y_BITS-1:0] tex_y;
        logic                  last;
    } t_vertex;

    t_vertex                  quad_corners[$];
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    logic [COORD_BITS-1:0]    col_q;
    logic [COORD_BITS-1:0]    row_q;
    int                       fail_total;
    int                       checked_total;
    int                       reports;

    initial begin
        fail_total    = 0;
        checked_total = 0;
        reports       = 0;
    end

    // zero acts as one, anything past the counter range is clamped
    function automatic int unsigned effective_dim(logic [CFG_DATA_BITS-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return v;
    endfunction

    function automatic void add_corner(int unsigned px, int unsigned py,
                                       int unsigned tx, int unsigned ty, logic last);
        t_vertex v;
        v.pos_x = POS_W'(px);
        v.pos_y = POS_W'(py);
        v.tex_x = TEX_X_BITS'(tx);
        v.tex_y = TEX_Y_BITS'(ty);
        v.last  = last;
        quad_corners.push_back(v);
    endfunction

    function automatic void predict_tile(logic [WORD_BITS-1:0] word);
        int unsigned         w, h, px, py, tx, ty, tx_a, tx_b, ty_a, ty_b;
        logic [IDX_BITS-1:0] tile_idx;
        w = effective_dim(width_reg);
        h = effective_dim(height_reg);
        if (col_q >= w) col_q = '0;
        if (row_q >= h) row_q = '0;
        if (word != '0) begin
            tile_idx = word[IDX_BITS-1:0];
            px   = col_q;
            py   = h - 1 - row_q;
            tx   = tile_idx[ATLAS_COL_BITS-1:0] * TILE_PIX;
            ty   = (tile_idx >> ATLAS_COL_BITS) * TILE_PIX;
            tx_a = word[FLIPX_BIT] ? tx + TILE_PIX : tx;
            tx_b = word[FLIPX_BIT] ? tx : tx + TILE_PIX;
            ty_a = word[FLIPY_BIT] ? ty + TILE_PIX : ty;
            ty_b = word[FLIPY_BIT] ? ty : ty + TILE_PIX;
            add_corner(px,     py,     tx_a, ty_b, 1'b0);
            add_corner(px + 1, py,     tx_b, ty_b, 1'b0);
            add_corner(px + 1, py + 1, tx_b, ty_a, 1'b0);
            add_corner(px,     py + 1, tx_a, ty_a, 1'b1);
        end
        if (col_q + 1 >= w) begin
            col_q = '0;
            row_q = (row_q + 1 >= h) ? '0 : row_q + 1'b1;
        end else begin
            col_q = col_q + 1'b1;
        end
    endfunction

    // writes to unknown indexes change nothing, the counters included
    function automatic void apply_write(logic [CFG_IDX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_MAP_WIDTH: begin
                width_reg = data;
            end
            REG_MAP_HEIGHT: begin
                height_reg = data;
            end
            default: begin
                return;
            end
        endcase
        col_q = '0;
        row_q = '0;
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_total++;
            if (reports < MAX_REPORTS)
                $display("%0t ns: vertex %0d %s mismatch: expected %0d, actual %0d",
                         $time, checked_total, field, want, got);
            reports++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_vertex got;
        t_vertex want;
        if (!i_rst_n) begin
            width_reg  = 1;
            height_reg = 1;
            col_q      = '0;
            row_q      = '0;
            quad_corners.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got = '{i_pos_x, i_pos_y, i_tex_x, i_tex_y, i_last_vertex};
                if (quad_corners.size() == 0) begin
                    fail_total++;
                    if (reports < MAX_REPORTS)
                        $display({"%0t ns: unexpected vertex: expected none, ",
                                  "actual %0d,%0d %0d,%0d last %0d"},
                                 $time, got.pos_x, got.pos_y, got.tex_x, got.tex_y,
                                 got.last);
                    reports++;
                end else begin
                    want = quad_corners.pop_front();
                    compare_field("pos_x", want.pos_x, got.pos_x);
                    compare_field("pos_y", want.pos_y, got.pos_y);
                    compare_field("tex_x", want.tex_x, got.tex_x);
                    compare_field("tex_y", want.tex_y, got.tex_y);
                    compare_field("last_vertex", want.last, got.last);
                end
                checked_total++;
            end
            if (i_cfg_we) apply_write(i_cfg_idx, i_cfg_data);
            if (i_push && !i_full) predict_tile(i_tile_word);
        end
        o_fail_count       <= fail_total;
        o_vertices_due     <= quad_corners.size();
        o_vertices_checked <= checked_total;
    end

endmodule

### sim/tb_tilemap_quad_vertex_generator.sv
// tb_tilemap_quad_vertex_generator: stimulus and verdict for the quad vertex generator
// drives tile words and map sizes, stalls both sides at random; checking is done
// by tmqv_vertex_checker; depends on tmqv_pkg and the generator rtl

module tb_tilemap_quad_vertex_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import tmqv_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int DIM_MAX    = 1 << COORD_BITS;

    // indexes past the two map registers, written to show they are ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [CFG_DATA_BITS-1:0] DATA_ALL    = '1;

    // tile word pieces
    localparam logic [WORD_BITS-1:0] FLIP_X  = 16'h8000;
    localparam logic [WORD_BITS-1:0] FLIP_Y  = 16'h4000;
    localparam logic [WORD_BITS-1:0] IDX_ALL = 16'h3fff;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;     // idle margin before a configuration write
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int EMPTY_RUN      = 6;     // length of each empty-cell run in the large-map tests

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                     push        = 1'b0;
    logic                     full;
    logic [WORD_BITS-1:0]     i_tile_word = '0;
    logic                     empty;
    logic                     pop         = 1'b0;
    logic [COORD_BITS:0]      o_pos_x;
    logic [COORD_BITS:0]      o_pos_y;
    logic [TEX_X_BITS-1:0]    o_tex_x;
    logic [TEX_Y_BITS-1:0]    o_tex_y;
    logic                     o_last_vertex;

    int fail_count;
    int vertices_due;
    int vertices_checked;

    // sender bookkeeping
    int words_sent      = 0;
    int empty_run_words = 0;
    int settings_used   = 0;
    bit sender_calm     = 1'b0;   // no gaps between words while set
    bit hold_requested  = 1'b0;   // asks the receiver for its long hold-off
    bit hold_done       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    tilemap_quad_vertex_generator #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_tile_word  (i_tile_word),
        .empty        (empty),
        .pop          (pop),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_tex_x      (o_tex_x),
        .o_tex_y      (o_tex_y),
        .o_last_vertex(o_last_vertex)
    );

    tmqv_vertex_checker #(
        .COORD_BITS(COORD_BITS)
    ) vertex_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .i_full            (full),
        .i_tile_word       (i_tile_word),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_pos_x           (o_pos_x),
        .i_pos_y           (o_pos_y),
        .i_tex_x           (o_tex_x),
        .i_tex_y           (o_tex_y),
        .i_last_vertex     (o_last_vertex),
        .o_fail_count      (fail_count),
        .o_vertices_due    (vertices_due),
        .o_vertices_checked(vertices_checked)
    );

    // mostly back to back, sometimes a few cycles, now and then a long gap
    function automatic int pick_gap();
        int unsigned r;
        if (sender_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // about a third empty cells, a few all-flags words, the rest anything
    function automatic logic [WORD_BITS-1:0] random_tile();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return '0;
        if (r < 35) return $urandom_range(0, 1) ? 16'hffff : (FLIP_X | FLIP_Y);
        return WORD_BITS'($urandom);
    endfunction

    // offer one tile word, hold it until taken, then maybe idle
    task automatic send_tile(input logic [WORD_BITS-1:0] word);
        int gap;
        push        <= 1'b1;
        i_tile_word <= word;
        do @(posedge i_clk); while (full);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // a run of empty cells with no gaps, only to move the counters on
    task automatic skip_cells(input int count);
        bit was_calm;
        was_calm    = sender_calm;
        sender_calm = 1'b1;
        repeat (count) send_tile('0);
        sender_calm = was_calm;
        empty_run_words += count;
    endtask

    // sender pause: every expected vertex has come back and the front end is idle
    task automatic wait_for_quiet();
        push <= 1'b0;
        @(posedge i_clk);
        while (vertices_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_map(input int unsigned w, input int unsigned h);
        wait_for_quiet();
        write_reg(REG_MAP_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_MAP_HEIGHT, CFG_DATA_BITS'(h));
        settings_used++;
    endtask

    task automatic random_phase(input int unsigned w, input int unsigned h, input int count);
        set_map(w, h);
        repeat (count) send_tile(random_tile());
    endtask

    // receiver: random pops with stalls and calm runs, plus one long hold-off on request
    initial begin : receiver
        int unsigned r;
        int          stall_left;
        int          calm_left;
        stall_left = 0;
        calm_left  = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_requested && !hold_done) begin
                // block fills up while the sender keeps offering words
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (calm_left > 0) begin
                pop <= 1'b1;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall_left = $urandom_range(8, 40);
                    pop <= 1'b0;
                end else if (r < 8) begin
                    calm_left = $urandom_range(20, 80);
                    pop <= 1'b1;
                end else if (r < 30) begin
                    pop <= 1'b0;
                end else begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || i_cfg_we) idle = 0;
            else idle++;
        end
        $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset map is 1x1: each word is a whole map and the counters wrap every time
        send_tile(16'h0001);
        send_tile('0);
        send_tile(IDX_ALL);
        send_tile(FLIP_X);
        send_tile(FLIP_Y);
        send_tile(FLIP_X | FLIP_Y);
        send_tile(16'hffff);
        send_tile(16'h0010);

        // 3x2 map with empty cells; the seventh word starts a new map
        set_map(3, 2);
        send_tile(16'h0005);
        send_tile('0);
        send_tile(FLIP_X | 16'h0123);
        send_tile(FLIP_Y | 16'h0abc);
        send_tile('0);
        send_tile(FLIP_X | FLIP_Y | 16'h0001);
        send_tile(16'h1234);

        // height-only write mid-map must restart at column 0, row 0
        wait_for_quiet();
        write_reg(REG_MAP_HEIGHT, 13'd4);
        send_tile(16'h0021);
        send_tile(FLIP_Y | 16'h00ff);

        // zero sizes act as one
        set_map(0, 0);
        send_tile(16'h2aaa);
        send_tile(16'h1555);

        // writes to spare indexes leave sizes and counters alone
        set_map(5, 5);
        send_tile(16'h0042);
        send_tile('0);
        wait_for_quiet();
        write_reg(REG_SPARE_LO, DATA_ALL);
        write_reg(REG_SPARE_HI, '0);
        send_tile(16'h0f0f);
        send_tile(FLIP_X | 16'h3000);

        // widest map, clamped from the largest value: one row, columns keep counting
        set_map(DATA_ALL, 1);
        skip_cells(EMPTY_RUN);
        send_tile(16'hffff);
        send_tile(16'h0001);

        // tallest map, one past the clamp: top row gives the highest y
        set_map(DIM_MAX + 1, 0);
        set_map(1, DIM_MAX + 1);
        send_tile(FLIP_X | IDX_ALL);
        skip_cells(EMPTY_RUN);
        send_tile(FLIP_Y | 16'h0777);

        // random maps and tile words
        random_phase(4, 3, 24);
        random_phase(1, 1, 20);

        // pressure: no sender gaps, only real tiles, receiver holds off for a long time
        set_map(6, 4);
        sender_calm    = 1'b1;
        hold_requested = 1'b1;
        repeat (30) send_tile(WORD_BITS'($urandom_range(1, 16'hffff)));
        sender_calm = 1'b0;

        random_phase(0, 3, 20);
        random_phase(5, 0, 20);
        random_phase(DIM_MAX, DIM_MAX, 20);
        random_phase(DATA_ALL, DIM_MAX + 1, 20);
        random_phase($urandom_range(1, 9), $urandom_range(1, 9), 24);
        sender_calm = 1'b1;
        random_phase($urandom_range(1, 20), $urandom_range(1, 20), 24);
        sender_calm = 1'b0;
        random_phase($urandom_range(2, 6), $urandom_range(2, 6), 30);

        // drain and let the block go quiet
        wait_for_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d tile words (%0d in empty runs) over %0d map sizes",
                 words_sent, empty_run_words, settings_used);
        $display("run: %0d vertices checked, %0d mismatches, %0d vertices still due",
                 vertices_checked, fail_count, vertices_due);
        if (fail_count == 0 && vertices_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/tmqv_pkg.sv
hw/rtl/tmqv_fifo.sv
hw/rtl/tmqv_front.sv
hw/rtl/tmqv_back.sv
hw/rtl/tilemap_quad_vertex_generator.sv
sim/tmqv_vertex_checker.sv
sim/tb_tilemap_quad_vertex_generator.sv
